/* src/wind_window_mean_mode_filter_top_assert.svh */
// ----------------------------------------------------------------------------
// wind window filter assertion macros
// clocked assertion helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef WIND_WINDOW_MEAN_MODE_FILTER_TOP_ASSERT_SVH
`define WIND_WINDOW_MEAN_MODE_FILTER_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define WWMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define WWMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/wwmf_pkg.sv */
// ----------------------------------------------------------------------------
// wwmf_pkg
// shared widths and codes of the wind window filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wwmf_pkg;

  // sample and result width
  localparam int unsigned DATA_W = 8;

  // direction bins and their index width
  localparam int unsigned DIR_BINS = 8;
  localparam int unsigned BIN_W    = 3;

  // channel selector codes
  typedef enum logic {
    CMD_SPEED = 1'b0,
    CMD_DIR   = 1'b1
  } cmd_t;

endpackage

/* src/wind_window_mean_mode_filter_top.sv */
// ----------------------------------------------------------------------------
// wind_window_mean_mode_filter_top
// windowed mean of speed samples and windowed mode of direction samples
// ----------------------------------------------------------------------------
// Each item selects a channel: speed items return the floor of the mean of
// the last WINDOW speed samples, direction items return the most frequent
// position 0..7 among the last WINDOW direction samples (values of 8 or more
// are kept but not counted; ties go to the lower bin unless the higher bin
// equals the newest sample). Both windows read as zero after reset. One item
// is worked at a time. The ring is walked one entry per cycle through its
// single read port and the last read is folded in during the drain state
// that follows. A speed result then passes the reciprocal multiply step and
// the finish step into the output register, and the next item can be
// accepted in the cycle after it is loaded. A direction result passes eight
// bin compares and the finish step. The finish step waits while the output
// register still holds an unaccepted result. A new item is taken as soon as
// the sequencer is idle, even while a result still waits in the output
// register.
`timescale 1ns / 1ps

`include "wind_window_mean_mode_filter_top_assert.svh"

module wind_window_mean_mode_filter_top #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [wwmf_pkg::DATA_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wwmf_pkg::DATA_W-1:0] out_filtered
);

  localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = $clog2(WINDOW * 255 + 1);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned DW    = wwmf_pkg::DATA_W;
  localparam int unsigned BW    = wwmf_pkg::BIN_W;
  localparam logic [AW-1:0]    LAST_IDX  = AW'(WINDOW - 1);
  localparam logic [BW-1:0]    LAST_BIN  = BW'(wwmf_pkg::DIR_BINS - 1);

  // reciprocal of WINDOW, exact floor for every window sum
  localparam int unsigned     RECIP_SH   = SUM_W + $clog2(WINDOW);
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SUM_W:0]  RECIP      = (SUM_W + 1)'(RECIP_FULL);
  localparam int unsigned     PROD_W     = 2 * SUM_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_BINS,
    ST_FIN
  } state_t;

  state_t               state_r;
  wwmf_pkg::cmd_t       cmd_r;
  logic [DW-1:0]        samp_r;
  logic [AW-1:0]        idx_r;
  logic                 tap_vld_r;
  logic [SUM_W-1:0]     sum_r;
  logic [DW-1:0]        quo_r;
  logic [BW-1:0]        step_r;
  logic [CNT_W-1:0]     cnt_r [wwmf_pkg::DIR_BINS];
  logic [CNT_W-1:0]     top_r;
  logic [BW-1:0]        best_r;
  logic                 out_valid_r;
  logic [DW-1:0]        out_filtered_r;

  logic                 accept;
  logic                 spd_wr;
  logic                 dir_wr;
  logic [DW-1:0]        spd_rd;
  logic [DW-1:0]        dir_rd;
  logic [DW-1:0]        tap;
  logic                 tap_counted;
  logic [BW-1:0]        cnt_addr;
  logic [CNT_W-1:0]     cnt_rd;
  logic [SUM_W-1:0]     alu_a;
  logic [SUM_W-1:0]     alu_b;
  logic [SUM_W-1:0]     alu_res;
  logic [PROD_W-1:0]    prod;
  logic [DW-1:0]        result;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign spd_wr   = accept && (wwmf_pkg::cmd_t'(in_command) == wwmf_pkg::CMD_SPEED);
  assign dir_wr   = accept && (wwmf_pkg::cmd_t'(in_command) == wwmf_pkg::CMD_DIR);

  // one ring per channel, both read at the scan index
  wwmf_ring #(.DEPTH(WINDOW), .AW(AW)) u_spd_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (spd_wr),
    .wr_data (in_sample),
    .rd_addr (idx_r),
    .rd_data (spd_rd)
  );

  wwmf_ring #(.DEPTH(WINDOW), .AW(AW)) u_dir_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (dir_wr),
    .wr_data (in_sample),
    .rd_addr (idx_r),
    .rd_data (dir_rd)
  );

  // tap of the channel in work
  assign tap         = (cmd_r == wwmf_pkg::CMD_DIR) ? dir_rd : spd_rd;
  assign tap_counted = (tap < DW'(wwmf_pkg::DIR_BINS));

  // bin counter port: tap value while scanning, bin index while ranking
  assign cnt_addr = (state_r == ST_BINS) ? step_r : tap[BW-1:0];
  assign cnt_rd   = cnt_r[cnt_addr];

  // window adder: accumulate the speed window one tap per cycle
  always_comb begin
    alu_a   = sum_r;
    alu_b   = SUM_W'(tap);
    alu_res = alu_a + alu_b;
  end

  // window sum times the reciprocal of WINDOW
  assign prod = PROD_W'(sum_r) * PROD_W'(RECIP);

  assign result = (cmd_r == wwmf_pkg::CMD_DIR) ? DW'(best_r) : quo_r;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tap_vld_r <= (state_r == ST_SCAN);
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      // fold in the tap read last cycle
      if (tap_vld_r) begin
        if (cmd_r == wwmf_pkg::CMD_DIR) begin
          if (tap_counted) begin
            cnt_r[cnt_addr] <= cnt_rd + CNT_W'(1);
          end
        end else begin
          sum_r <= alu_res;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= wwmf_pkg::cmd_t'(in_command);
            samp_r  <= in_sample;
            idx_r   <= '0;
            sum_r   <= '0;
            quo_r   <= '0;
            for (int b = 0; b < wwmf_pkg::DIR_BINS; b++) begin
              cnt_r[b] <= '0;
            end
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (cmd_r == wwmf_pkg::CMD_DIR) begin
            step_r  <= '0;
            state_r <= ST_BINS;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // floor of the window mean by reciprocal multiply
          quo_r   <= prod[RECIP_SH +: DW];
          state_r <= ST_FIN;
        end
        ST_BINS: begin
          // bin zero seeds the winner, later bins need more or a tie on newest
          if (step_r == '0) begin
            top_r  <= cnt_rd;
            best_r <= '0;
          end else if (cnt_rd > top_r) begin
            top_r  <= cnt_rd;
            best_r <= step_r;
          end else if ((cnt_rd == top_r) && (samp_r == DW'(step_r))) begin
            best_r <= step_r;
          end
          if (step_r == LAST_BIN) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + BW'(1);
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_filtered_r <= result;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  // sequencer checks
  `WWMF_ASSERT(a_accept_leaves_idle, accept |=> (state_r == ST_SCAN),
               "accepted item did not start the ring scan")
  `WWMF_ASSERT(a_div_is_speed, (state_r == ST_DIV) |-> (cmd_r == wwmf_pkg::CMD_SPEED),
               "divide step on a direction item")
  `WWMF_ASSERT(a_bins_is_dir, (state_r == ST_BINS) |-> (cmd_r == wwmf_pkg::CMD_DIR),
               "bin ranking on a speed item")
  `WWMF_ASSERT(a_fin_loads_out, ((state_r == ST_FIN) && (!out_valid_r || out_ready)) |=>
               (out_valid_r && (state_r == ST_IDLE)),
               "finished result not moved to the output register")
  `WWMF_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && (state_r == ST_IDLE)),
                      "reset left a result or a busy sequencer")

endmodule

/* src/wwmf_ring.sv */
// ----------------------------------------------------------------------------
// wwmf_ring
// sample ring with write position, per-entry valid bits, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wwmf_ring #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [wwmf_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [wwmf_pkg::DATA_W-1:0] rd_data
);

  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  logic [wwmf_pkg::DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [AW-1:0]               pos_r;
  logic [wwmf_pkg::DATA_W-1:0] mem_q_r;
  logic                        vld_q_r;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  // valid bits and write position, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      pos_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[pos_r] <= 1'b1;
        pos_r        <= (pos_r == LAST_POS) ? '0 : pos_r + AW'(1);
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule
